@@ src/three_locus_chi_square_top_assert.svh @@
// assertion macros for the three-locus chi-square block
`ifndef THREE_LOCUS_CHI_SQUARE_TOP_ASSERT_SVH
`define THREE_LOCUS_CHI_SQUARE_TOP_ASSERT_SVH

// property checked only out of reset
`define TLCS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tlcs assertion failed");

// property checked also during reset
`define TLCS_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("tlcs reset assertion failed");

`endif

@@ src/tlcs_pkg.sv @@
// shared types and constants of the three-locus chi-square block
`default_nettype none
package tlcs_pkg;
    localparam int MAX_SUBJECTS_DEF = 4096;
    localparam int NUM_BINS         = 27;
    localparam int BIN_W            = 5;
    localparam int GT_W             = 2;
    localparam int CHI_W            = 29;
    localparam int TOTAL_W          = 13;
    localparam int QDEPTH           = 4;
    localparam logic [GT_W-1:0] GT_MAX = 2'd2;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             is_case;
        logic             last;
    } t_item;
endpackage
`default_nettype wire

@@ src/three_locus_chi_square_top.sv @@
// top level of the three-locus chi-square block
// channel   handshake              payload
// subject   start / busy           genotypes, is_case, last_subject
// result    o_valid strobe         chi_square_value, subject_total, count_overflow
// a subject is counted once it leaves the queue; subjects stream at one per cycle while busy is low
// on a last subject the reduction walks the 27 bins in turn, dividing for each nonempty bin
// in the one shared restoring divider, one quotient bit a cycle
// busy rises while the four-entry queue is full, mostly during reduction
// synchronous active-low reset clears counts, queue and state; no clearing pass
`default_nettype none
module three_locus_chi_square_top #(
    parameter int MAX_SUBJECTS = tlcs_pkg::MAX_SUBJECTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [tlcs_pkg::GT_W-1:0]    i_first_genotype,
    input  wire logic [tlcs_pkg::GT_W-1:0]    i_second_genotype,
    input  wire logic [tlcs_pkg::GT_W-1:0]    i_third_genotype,
    input  wire logic                         i_is_case,
    input  wire logic                         i_last_subject,
    output logic                              o_valid,
    output logic [tlcs_pkg::CHI_W-1:0]        o_chi_square_value,
    output logic [tlcs_pkg::TOTAL_W-1:0]      o_subject_total,
    output logic                              o_count_overflow
);
    tlcs_pkg::t_item f_item, q_item;
    logic push, pop, empty, full;

    assign busy = full;

    tlcs_front u_front (
        .i_first_genotype (i_first_genotype),
        .i_second_genotype(i_second_genotype),
        .i_third_genotype (i_third_genotype),
        .i_is_case        (i_is_case),
        .i_last_subject   (i_last_subject),
        .i_start          (start),
        .i_full           (full),
        .o_item           (f_item),
        .o_push           (push)
    );

    tlcs_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (f_item),
        .i_pop  (pop),
        .o_item (q_item),
        .o_empty(empty),
        .o_full (full)
    );

    tlcs_back #(.MAX_SUBJECTS(MAX_SUBJECTS)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (q_item),
        .i_empty           (empty),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .o_chi_square_value(o_chi_square_value),
        .o_subject_total   (o_subject_total),
        .o_count_overflow  (o_count_overflow)
    );
endmodule
`default_nettype wire

@@ src/tlcs_front.sv @@
// front end: takes a subject and works out its combination bin
`default_nettype none
module tlcs_front (
    input  wire logic [tlcs_pkg::GT_W-1:0] i_first_genotype,
    input  wire logic [tlcs_pkg::GT_W-1:0] i_second_genotype,
    input  wire logic [tlcs_pkg::GT_W-1:0] i_third_genotype,
    input  wire logic                      i_is_case,
    input  wire logic                      i_last_subject,
    input  wire logic                      i_start,
    input  wire logic                      i_full,
    output tlcs_pkg::t_item                o_item,
    output logic                           o_push
);
    logic [tlcs_pkg::GT_W-1:0] g0, g1, g2;

    always_comb begin
        g0 = (i_first_genotype  > tlcs_pkg::GT_MAX) ? tlcs_pkg::GT_MAX : i_first_genotype;
        g1 = (i_second_genotype > tlcs_pkg::GT_MAX) ? tlcs_pkg::GT_MAX : i_second_genotype;
        g2 = (i_third_genotype  > tlcs_pkg::GT_MAX) ? tlcs_pkg::GT_MAX : i_third_genotype;
        o_item.bin = tlcs_pkg::BIN_W'(g0) * tlcs_pkg::BIN_W'(9)
                   + tlcs_pkg::BIN_W'(g1) * tlcs_pkg::BIN_W'(3)
                   + tlcs_pkg::BIN_W'(g2);
        o_item.is_case = i_is_case;
        o_item.last    = i_last_subject;
        o_push = i_start & ~i_full;
    end
endmodule
`default_nettype wire

@@ src/tlcs_queue.sv @@
// short queue of classified subjects between front and back
`default_nettype none
module tlcs_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire tlcs_pkg::t_item i_item,
    input  wire logic            i_pop,
    output tlcs_pkg::t_item      o_item,
    output logic                 o_empty,
    output logic                 o_full
);
    localparam int PW = $clog2(tlcs_pkg::QDEPTH);
    localparam int CW = $clog2(tlcs_pkg::QDEPTH + 1);

    tlcs_pkg::t_item r_mem [tlcs_pkg::QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_item  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(tlcs_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_item;
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

@@ src/tlcs_back.sv @@
// back end: bin counting and the sequential chi-square reduction
`default_nettype none
module tlcs_back #(
    parameter int MAX_SUBJECTS = tlcs_pkg::MAX_SUBJECTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tlcs_pkg::t_item              i_item,
    input  wire logic                         i_empty,
    output logic                              o_pop,
    output logic                              o_valid,
    output logic [tlcs_pkg::CHI_W-1:0]        o_chi_square_value,
    output logic [tlcs_pkg::TOTAL_W-1:0]      o_subject_total,
    output logic                              o_count_overflow
);
    localparam int CW  = $clog2(MAX_SUBJECTS + 1);
    localparam int SW  = 2 * CW;
    localparam int PW  = 3 * CW;
    localparam int XW  = 4 * CW;
    localparam int DW  = XW + 32;
    localparam int DCW = $clog2(DW);
    localparam logic [63:0] CHI_MAX = 64'h1FFF_FFFF;

    typedef enum logic [3:0] {
        S_CNT, S_D, S_RD, S_SQ, S_MUL, S_X, S_DIV, S_ACC, S_FIN
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_case [tlcs_pkg::NUM_BINS];
    logic [CW-1:0]        r_ctrl [tlcs_pkg::NUM_BINS];
    logic [CW-1:0]        r_tcase, r_tctrl, r_n, r_f0, r_f1, r_c;
    logic                 r_ovf;
    logic [SW-1:0]        r_d, r_f0sq, r_f1sq;
    logic [PW-1:0]        r_a, r_b, r_cd, r_rem;
    logic [XW-1:0]        r_x;
    logic [DW-1:0]        r_dvd, r_q;
    logic [DCW-1:0]       r_cnt;
    logic [63:0]          r_acc;
    logic [tlcs_pkg::BIN_W-1:0] r_j;
    logic                 r_valid;
    logic [tlcs_pkg::CHI_W-1:0]   r_chi;
    logic [tlcs_pkg::TOTAL_W-1:0] r_tot;
    logic                 r_ovf_out;

    logic [tlcs_pkg::BIN_W-1:0] idx;
    logic [CW-1:0]        rd_case, rd_ctrl;
    logic [CW:0]          total;
    logic [PW:0]          rem_sh;
    logic                 ge;
    logic [63:0]          base, diff;

    always_comb begin
        idx     = (r_state == S_CNT) ? i_item.bin : r_j;
        rd_case = r_case[idx];
        rd_ctrl = r_ctrl[idx];
        total   = {1'b0, r_tcase} + {1'b0, r_tctrl};
        o_pop   = (r_state == S_CNT) && !i_empty;
        rem_sh  = {r_rem, r_dvd[DW-1]};
        ge      = rem_sh >= {1'b0, r_cd};
        base    = {32'(r_n), 32'b0};
        diff    = (r_acc - base) >> 16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CNT;
            r_tcase <= '0;
            r_tctrl <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
            r_dvd   <= '0;
            for (int k = 0; k < tlcs_pkg::NUM_BINS; k++) begin
                r_case[k] <= '0;
                r_ctrl[k] <= '0;
            end
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CNT: begin
                    if (!i_empty) begin
                        if (total >= (CW+1)'(MAX_SUBJECTS)) begin
                            r_ovf <= 1'b1;
                        end else if (i_item.is_case) begin
                            r_case[idx] <= rd_case + CW'(1);
                            r_tcase     <= r_tcase + CW'(1);
                        end else begin
                            r_ctrl[idx] <= rd_ctrl + CW'(1);
                            r_tctrl     <= r_tctrl + CW'(1);
                        end
                        if (i_item.last) begin
                            r_state <= S_D;
                        end
                    end
                end
                S_D: begin
                    r_n   <= CW'(total);
                    r_d   <= SW'(r_tcase) * SW'(r_tctrl);
                    r_acc <= '0;
                    r_j   <= '0;
                    r_state <= (r_tcase == '0 || r_tctrl == '0) ? S_FIN : S_RD;
                end
                S_RD: begin
                    r_f0 <= rd_ctrl;
                    r_f1 <= rd_case;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_c    <= r_f0 + r_f1;
                    r_f0sq <= SW'(r_f0) * SW'(r_f0);
                    r_f1sq <= SW'(r_f1) * SW'(r_f1);
                    r_q    <= '0;
                    r_state <= (r_f0 == '0 && r_f1 == '0) ? S_ACC : S_MUL;
                end
                S_MUL: begin
                    r_a  <= PW'(r_f0sq) * PW'(r_tcase);
                    r_b  <= PW'(r_f1sq) * PW'(r_tctrl);
                    r_cd <= PW'(r_c) * PW'(r_d);
                    r_state <= S_X;
                end
                S_X: begin
                    r_x   <= XW'(r_a + r_b) * XW'(r_n);
                    r_rem <= '0;
                    r_cnt <= DCW'(DW - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == DCW'(DW - 1) && r_dvd != {r_x, 32'b0}) begin
                        r_dvd <= {r_x, 32'b0};
                    end else begin
                        r_rem <= ge ? PW'(rem_sh - {1'b0, r_cd}) : PW'(rem_sh);
                        r_q   <= {r_q[DW-2:0], ge};
                        r_dvd <= {r_dvd[DW-2:0], 1'b0};
                        r_cnt <= r_cnt - DCW'(1);
                        if (r_cnt == '0) begin
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    r_acc <= r_acc + 64'(r_q);
                    if (r_j == tlcs_pkg::BIN_W'(tlcs_pkg::NUM_BINS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_j <= r_j + tlcs_pkg::BIN_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    if (r_acc <= base) begin
                        r_chi <= '0;
                    end else if (diff > CHI_MAX) begin
                        r_chi <= tlcs_pkg::CHI_W'(CHI_MAX);
                    end else begin
                        r_chi <= tlcs_pkg::CHI_W'(diff);
                    end
                    r_tot     <= tlcs_pkg::TOTAL_W'(total);
                    r_ovf_out <= r_ovf;
                    r_valid   <= 1'b1;
                    r_tcase   <= '0;
                    r_tctrl   <= '0;
                    r_ovf     <= 1'b0;
                    for (int k = 0; k < tlcs_pkg::NUM_BINS; k++) begin
                        r_case[k] <= '0;
                        r_ctrl[k] <= '0;
                    end
                    r_state <= S_CNT;
                end
                default: r_state <= S_CNT;
            endcase
        end
    end

    assign o_valid            = r_valid;
    assign o_chi_square_value = r_chi;
    assign o_subject_total    = r_tot;
    assign o_count_overflow   = r_ovf_out;
endmodule
`default_nettype wire

@@ src/tlcs_checker.sv @@
// port-level checker for the three-locus chi-square block
`default_nettype none
`include "three_locus_chi_square_top_assert.svh"
module tlcs_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);
    `TLCS_ASSERT(a_strobe_single, o_valid |=> !o_valid)
    `TLCS_ASSERT(a_busy_after_transfer, $rose(busy) |-> $past(start))
    `TLCS_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_valid && !busy)
endmodule

bind three_locus_chi_square_top tlcs_checker u_tlcs_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_valid(o_valid)
);
`default_nettype wire

@@ verif/three_locus_chi_square_top_tb.sv @@
// testbench of the three-locus chi-square block: table of subjects, random sets, scoreboard
`timescale 1ns / 1ps
`default_nettype none
module three_locus_chi_square_top_tb;

    typedef struct {
        bit [tlcs_pkg::GT_W-1:0]    g0;
        bit [tlcs_pkg::GT_W-1:0]    g1;
        bit [tlcs_pkg::GT_W-1:0]    g2;
        bit                         cs;
        bit                         lst;
        bit                         typed;
        bit [tlcs_pkg::CHI_W-1:0]   chi;
        bit [tlcs_pkg::TOTAL_W-1:0] tot;
        bit                         ovf;
    } t_row;

    typedef struct {
        bit [tlcs_pkg::CHI_W-1:0]   chi;
        bit [tlcs_pkg::TOTAL_W-1:0] tot;
        bit                         ovf;
    } t_stat;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [tlcs_pkg::GT_W-1:0]      i_first_genotype = '0;
    logic [tlcs_pkg::GT_W-1:0]      i_second_genotype = '0;
    logic [tlcs_pkg::GT_W-1:0]      i_third_genotype = '0;
    logic                           i_is_case = 1'b0;
    logic                           i_last_subject = 1'b0;
    logic                           o_valid;
    logic [tlcs_pkg::CHI_W-1:0]     o_chi_square_value;
    logic [tlcs_pkg::TOTAL_W-1:0]   o_subject_total;
    logic                           o_count_overflow;

    bit [63:0] case_bins [tlcs_pkg::NUM_BINS];
    bit [63:0] ctrl_bins [tlcs_pkg::NUM_BINS];
    bit [63:0] case_sum;
    bit [63:0] ctrl_sum;
    bit        ovf_seen;
    t_stat     pending_stats [$];
    int        mismatches = 0;
    bit        calm = 1'b0;

    t_row table_rows [] = '{
        '{0, 0, 0, 1, 1, 1, 0, 1, 0},
        '{3, 3, 3, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 1, 1, 1, 131072, 2, 0},
        '{1, 2, 0, 1, 0, 0, 0, 0, 0},
        '{2, 1, 1, 0, 0, 0, 0, 0, 0},
        '{0, 1, 2, 1, 0, 0, 0, 0, 0},
        '{3, 0, 3, 0, 0, 0, 0, 0, 0},
        '{1, 1, 1, 1, 0, 0, 0, 0, 0},
        '{2, 2, 2, 0, 1, 0, 0, 0, 0},
        '{2, 0, 1, 0, 0, 0, 0, 0, 0},
        '{1, 0, 2, 0, 1, 1, 0, 2, 0},
        '{3, 3, 3, 1, 0, 0, 0, 0, 0},
        '{0, 3, 0, 0, 0, 0, 0, 0, 0},
        '{3, 0, 0, 1, 1, 0, 0, 0, 0}
    };

    three_locus_chi_square_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_first_genotype   (i_first_genotype),
        .i_second_genotype  (i_second_genotype),
        .i_third_genotype   (i_third_genotype),
        .i_is_case          (i_is_case),
        .i_last_subject     (i_last_subject),
        .o_valid            (o_valid),
        .o_chi_square_value (o_chi_square_value),
        .o_subject_total    (o_subject_total),
        .o_count_overflow   (o_count_overflow)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit [tlcs_pkg::CHI_W-1:0] chi_q16();
        bit [63:0]  r0;
        bit [63:0]  r1;
        bit [63:0]  n;
        bit [63:0]  d;
        bit [63:0]  acc;
        bit [63:0]  base;
        bit [63:0]  chi;
        bit [63:0]  f0;
        bit [63:0]  f1;
        bit [63:0]  c;
        bit [63:0]  t;
        bit [127:0] x;
        r0 = ctrl_sum;
        r1 = case_sum;
        n = r0 + r1;
        d = r0 * r1;
        acc = '0;
        if (r0 == 0 || r1 == 0) return '0;
        for (int j = 0; j < tlcs_pkg::NUM_BINS; j++) begin
            f0 = ctrl_bins[j];
            f1 = case_bins[j];
            c = f0 + f1;
            if (c == 0) continue;
            t = f0 * f0 * r1 + f1 * f1 * r0;
            x = {64'd0, 64'(t * n)} << 32;
            acc += 64'(x / {64'd0, 64'(c * d)});
        end
        base = n << 32;
        if (acc <= base) return '0;
        chi = (acc - base) >> 16;
        if (chi > 64'h1FFF_FFFF) chi = 64'h1FFF_FFFF;
        return chi[tlcs_pkg::CHI_W-1:0];
    endfunction

    task automatic clear_tallies();
        for (int j = 0; j < tlcs_pkg::NUM_BINS; j++) begin
            case_bins[j] = '0;
            ctrl_bins[j] = '0;
        end
        case_sum = '0;
        ctrl_sum = '0;
        ovf_seen = 1'b0;
    endtask

    // counts one subject and returns the running statistic; clears the tallies when it closes the set
    task automatic tally_subject(input t_row r, output t_stat s);
        int g [3];
        int b;
        g[0] = (r.g0 > tlcs_pkg::GT_MAX) ? tlcs_pkg::GT_MAX : r.g0;
        g[1] = (r.g1 > tlcs_pkg::GT_MAX) ? tlcs_pkg::GT_MAX : r.g1;
        g[2] = (r.g2 > tlcs_pkg::GT_MAX) ? tlcs_pkg::GT_MAX : r.g2;
        b = g[0] * 9 + g[1] * 3 + g[2];
        if (case_sum + ctrl_sum >= tlcs_pkg::MAX_SUBJECTS_DEF) begin
            ovf_seen = 1'b1;
        end else if (r.cs) begin
            case_bins[b]++;
            case_sum++;
        end else begin
            ctrl_bins[b]++;
            ctrl_sum++;
        end
        s.chi = chi_q16();
        s.tot = tlcs_pkg::TOTAL_W'(case_sum + ctrl_sum);
        s.ovf = ovf_seen;
        if (r.lst) clear_tallies();
    endtask

    task automatic send_subject(input t_row r);
        t_stat s;
        bit    taken;
        start <= 1'b1;
        i_first_genotype <= r.g0;
        i_second_genotype <= r.g1;
        i_third_genotype <= r.g2;
        i_is_case <= r.cs;
        i_last_subject <= r.lst;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        tally_subject(r, s);
        if (r.lst) begin
            if (r.typed) begin
                s.chi = r.chi;
                s.tot = r.tot;
                s.ovf = r.ovf;
            end
            pending_stats.push_back(s);
        end
        if (!calm) begin
            while ($urandom_range(99) < 28) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    task automatic send_set(input int size, input int bias);
        t_row r;
        for (int k = 0; k < size; k++) begin
            r = '{default: 0};
            r.g0 = $urandom_range(3);
            r.g1 = $urandom_range(3);
            r.g2 = $urandom_range(3);
            r.cs = ($urandom_range(99) < bias);
            r.lst = (k == size - 1);
            send_subject(r);
        end
    endtask

    always @(negedge i_clk) begin
        t_stat e;
        if (i_rst_n && o_valid) begin
            if (pending_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer chi=%0d", o_chi_square_value);
            end else begin
                e = pending_stats.pop_front();
                if (o_chi_square_value !== e.chi || o_subject_total !== e.tot
                        || o_count_overflow !== e.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp chi=%0d tot=%0d ovf=%0d ",
                                  "got chi=%0d tot=%0d ovf=%0d"},
                                 e.chi, e.tot, e.ovf, o_chi_square_value, o_subject_total,
                                 o_count_overflow);
                end
            end
        end
    end

    initial begin
        #(20 * 20_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int drained;
        clear_tallies();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (table_rows[i]) send_subject(table_rows[i]);
        for (int n = 0; n < 35; n++) begin
            calm = (n >= 12 && n < 22);
            if (n == 26) begin
                start <= 1'b0;
                while (pending_stats.size() != 0) @(posedge i_clk);
            end
            case ($urandom_range(9))
                0:       send_set($urandom_range(100, 250), 50);
                1:       send_set($urandom_range(1, 12), $urandom_range(1) * 100);
                default: send_set($urandom_range(1, 30), $urandom_range(10, 90));
            endcase
        end
        calm = 1'b0;
        send_set($urandom_range(2, 20), 50);
        start <= 1'b0;
        drained = 0;
        while (pending_stats.size() != 0 && drained < 200_000) begin
            @(posedge i_clk);
            drained++;
        end
        repeat (3000) @(posedge i_clk);
        if (mismatches == 0 && pending_stats.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ three_locus_chi_square_top.f @@
+incdir+src
src/tlcs_pkg.sv
src/tlcs_front.sv
src/tlcs_queue.sv
src/tlcs_back.sv
src/three_locus_chi_square_top.sv
src/tlcs_checker.sv
verif/three_locus_chi_square_top_tb.sv
